// File: rtl/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication or property on every clock edge outside reset
`define PWLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define PWLI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PWLI_ASSERT(lbl, clk, rst_n, prop, msg)
`define PWLI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/pwli_pkg.sv
// Types and constants for the piecewise linear interpolator.
// No dependencies; used by pwli_muldiv and the core top level.
package pwli_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned OP_W       = DATA_W + 1;
  localparam int unsigned HALF_W     = 17;
  localparam int unsigned PP_W       = 2 * HALF_W;
  localparam int unsigned PROD_W     = 2 * OP_W;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned MUL_LAST   = 3;
  localparam int unsigned DIV_LAST   = OP_W - 1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     in_range;
  } out_item_t;

  // Operands of one scaled quotient floor(mag * off / span)
  typedef struct packed {
    logic [OP_W-1:0] mag;
    logic [OP_W-1:0] off;
    logic [OP_W-1:0] span;
  } md_req_t;

endpackage

// File: rtl/pwli_muldiv.sv
// Sequential multiply-divide unit: floor(mag * off / span) with off <= span.
// Four 17x17 partial products, then 33 restoring division steps. Uses pwli_pkg.
module pwli_muldiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  pwli_pkg::md_req_t          req_i,
  output logic                       done_o,
  output logic [pwli_pkg::OP_W-1:0]  quot_o
);
  import pwli_pkg::*;

  md_state_e         state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [OP_W-1:0]   a_q, b_q, span_q;
  logic [PROD_W-1:0] prod_q;
  logic [OP_W-1:0]   rem_q, shr_q, quot_q;

  logic [HALF_W-1:0] a_part, b_part;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] pp_sh, prod_sum;
  logic [OP_W+1:0]   trial;
  logic              take;

  // Select halves and form one partial product per cycle
  always_comb begin
    a_part = step_q[0] ? {1'b0, a_q[OP_W-1:HALF_W]} : a_q[HALF_W-1:0];
    b_part = step_q[1] ? {1'b0, b_q[OP_W-1:HALF_W]} : b_q[HALF_W-1:0];
    pp     = a_part * b_part;
    unique case (step_q[1:0])
      2'd0:    pp_sh = PROD_W'(pp);
      2'd1,
      2'd2:    pp_sh = PROD_W'(pp) << HALF_W;
      default: pp_sh = PROD_W'(pp) << (2 * HALF_W);
    endcase
    prod_sum = prod_q + pp_sh;
  end

  // Trial subtract for one quotient bit
  always_comb begin
    trial = {1'b0, rem_q, shr_q[OP_W-1]} - {2'b00, span_q};
    take  = ~trial[OP_W+1];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL;
      MD_MUL:  if (step_q == STEP_W'(MUL_LAST)) state_d = MD_DIV;
      MD_DIV:  if (step_q == STEP_W'(DIV_LAST)) state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MD_DIV) && (step_q == STEP_W'(DIV_LAST));
      if (state_q != state_d) begin
        step_q <= '0;
      end else if (state_q != MD_IDLE) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  // Datapath: load operands, accumulate product, shift out quotient bits
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          a_q    <= req_i.mag;
          b_q    <= req_i.off;
          span_q <= req_i.span;
          prod_q <= '0;
        end
      end
      MD_MUL: begin
        prod_q <= prod_sum;
        // High half of the product is already below span
        rem_q  <= prod_sum[PROD_W-1:OP_W];
        shr_q  <= prod_sum[OP_W-1:0];
      end
      MD_DIV: begin
        rem_q  <= take ? trial[OP_W-1:0] : {rem_q[OP_W-2:0], shr_q[OP_W-1]};
        shr_q  <= {shr_q[OP_W-2:0], 1'b0};
        quot_q <= {quot_q[OP_W-2:0], take};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator core: breakpoint table in two synchronous
// memories, serial segment scan, and the pwli_muldiv unit. Uses pwli_pkg.
//
//   port group   dir  handshake                  payload
//   in_*         in   in_valid_i / in_stall_o    in_item_i  (pwli_pkg::in_item_t)
//   out_*        out  out_valid_o / out_stall_i  out_item_o (pwli_pkg::out_item_t)
//   cfg_*        in   cfg_we_i                   cfg_wdata_i (point_count)
//
// A load item writes one table entry. A query scans the table one entry a
// cycle through the memory read port, then runs the multiply and divide steps
// in the muldiv unit.
// Reset sets point_count to 2; table contents are undefined until loaded.
// The result sits in an output register, so a stalled output holds only the
// next query's finish, not the acceptance of the next item.
`include "assert_macros.svh"

module piecewise_linear_interpolator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pwli_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pwli_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [pwli_pkg::CNT_W-1:0]    cfg_wdata_i
);
  import pwli_pkg::*;

  // Table memories
  logic [DATA_W-1:0] break_x_q [MAX_POINTS];
  logic [DATA_W-1:0] break_y_q [MAX_POINTS];

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         n_eff;
  logic [IDX_W-1:0]         n_last_q;
  logic [IDX_W-1:0]         addr_q, rdk_q;
  logic                     rdv_q;
  logic signed [DATA_W-1:0] qx_q;
  logic [DATA_W-1:0]        rd_x_q, rd_y_q, prev_x_q, prev_y_q;
  logic signed [DATA_W-1:0] y0_q;
  logic                     neg_q;
  out_item_t                res_q, out_q;
  logic                     out_valid_q;

  logic             in_acc, load_acc, query_acc, few_points;
  logic             hit, miss_end, vertical, md_start, md_done, out_load;
  logic [OP_W-1:0]  md_quot;
  md_req_t          md_req;
  logic signed [OP_W-1:0] dy, span_s, off_s;
  logic signed [OP_W:0]   res_sum;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (in_item_i.cmd == CMD_LOAD);
  assign query_acc  = in_acc && (in_item_i.cmd == CMD_QUERY);
  assign n_eff      = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
  assign few_points = n_eff < CNT_W'(2);

  // Segment test on the entry pair (rdk - 1, rdk)
  always_comb begin
    hit      = rdv_q && (rdk_q != '0) &&
               ($signed(prev_x_q) <= qx_q) && (qx_q <= $signed(rd_x_q));
    miss_end = rdv_q && !hit && (rdk_q == n_last_q);
    span_s   = OP_W'($signed(rd_x_q)) - OP_W'($signed(prev_x_q));
    off_s    = OP_W'(qx_q) - OP_W'($signed(prev_x_q));
    dy       = OP_W'($signed(rd_y_q)) - OP_W'($signed(prev_y_q));
    vertical = (span_s == '0);
    md_req.mag  = dy[OP_W-1] ? OP_W'(-dy) : OP_W'(dy);
    md_req.off  = off_s;
    md_req.span = span_s;
  end

  // Final value: y0 plus or minus the quotient
  always_comb begin
    res_sum = neg_q ? ((OP_W+1)'(y0_q) - $signed({1'b0, md_quot}))
                    : ((OP_W+1)'(y0_q) + $signed({1'b0, md_quot}));
  end

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    md_start   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (query_acc) state_d = few_points ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          md_start = !vertical;
          state_d  = vertical ? ST_DONE : ST_CALC;
        end else if (miss_end) begin
          state_d = ST_DONE;
        end
      end
      ST_CALC: begin
        if (md_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CNT_W'(2);
      rdv_q       <= 1'b0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
      rdv_q <= (state_q == ST_SCAN) && (state_d == ST_SCAN);
      if (query_acc) begin
        addr_q <= '0;
      end else if (state_q == ST_SCAN) begin
        addr_q <= addr_q + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table write on load, one read per cycle during the scan
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      break_x_q[in_item_i.entry_index] <= in_item_i.point_x;
      break_y_q[in_item_i.entry_index] <= in_item_i.point_y;
    end
    if (state_q == ST_SCAN) begin
      rd_x_q <= break_x_q[addr_q];
      rd_y_q <= break_y_q[addr_q];
    end
  end

  // Scan and result payload
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      qx_q     <= in_item_i.query_x;
      n_last_q <= IDX_W'(n_eff - CNT_W'(1));
      res_q    <= '{value: '0, in_range: 1'b0};
    end
    if (state_q == ST_SCAN) begin
      rdk_q    <= addr_q;
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
      if (hit) begin
        y0_q  <= $signed(prev_y_q);
        neg_q <= dy[OP_W-1];
        res_q <= '{value: $signed(prev_y_q), in_range: 1'b1};
      end
    end
    if ((state_q == ST_CALC) && md_done) begin
      res_q <= '{value: res_sum[DATA_W-1:0], in_range: 1'b1};
    end
    if (out_load) out_q <= res_q;
  end

  pwli_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .req_i   (md_req),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `PWLI_ASSERT(a_miss_zero, clk_i, rst_ni, (out_valid_o && !out_item_o.in_range) |-> (out_item_o.value == '0), "out-of-range result with nonzero value")
  `PWLI_ASSERT_NEVER(a_done_calc, clk_i, rst_ni, md_done && (state_q != ST_CALC), "muldiv finished outside calc")
  `PWLI_ASSERT(a_scan_bound, clk_i, rst_ni, (state_q == ST_SCAN && rdv_q) |-> (rdk_q <= n_last_q), "scan ran past last point")
  `PWLI_ASSERT(a_few_points, clk_i, rst_ni, (query_acc && few_points) |=> (state_q == ST_DONE), "short table did not answer at once")

endmodule
